// ===== hw/rtl/gedd_pkg.sv =====
// ----------------------------------------------------------------------------
// gedd_pkg: shared types and constants of the gray error-diffusion ditherer
// Register map codes, pixel and config structs, back-end sequencer states.
// ----------------------------------------------------------------------------
package gedd_pkg;

  // default row store depth (pixels per row)
  localparam int MAX_WIDTH_DEF = 1024;

  // entries in the queue between front and back end
  localparam int FRONT_DEPTH = 4;

  // width of one stored error value
  localparam int ERR_W = 13;

  // luminance weights, Q0.16, sum to 65536
  localparam logic [13:0] LUM_KR = 14'd13933;
  localparam logic [15:0] LUM_KG = 16'd46871;
  localparam logic [12:0] LUM_KB = 13'd4732;

  // ceil(2^32 / 255): x * RECIP_255 >> 32 == x / 255 for x < 2^24
  localparam logic [24:0] RECIP_255 = 25'h1010102;

  // register indexes, byte address 4*index
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_LEVEL_COUNT    = 2'd1,
    REG_ERROR_GAIN     = 2'd2,
    REG_ALPHA_TO_BLACK = 2'd3
  } reg_idx_t;

  // one classified input pixel
  typedef struct packed {
    logic       sof;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       transparent;
  } pix_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [10:0] image_width;
    logic [7:0]  levels;       // level count, already raised to at least 2
    logic [7:0]  error_gain;
    logic        alpha_to_black;
    logic [7:0]  level_step;
    logic        step_busy;    // level_step divider still running
  } cfg_t;

  // back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_PROD,
    ST_SUM,
    ST_DIV,
    ST_LVL,
    ST_GRAY,
    ST_Q,
    ST_FIN,
    ST_LAST
  } back_state_t;

endpackage

// ===== hw/rtl/gedd_ram.sv =====
// ----------------------------------------------------------------------------
// gedd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gedd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

// ===== hw/rtl/gedd_cfg.sv =====
// ----------------------------------------------------------------------------
// gedd_cfg: APB register file and level step divider
// Holds the four setup registers and derives level_step = 255 / (N-1)
// with a bit-serial divider, one quotient bit per cycle while no register is written.
// ----------------------------------------------------------------------------
module gedd_cfg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output gedd_pkg::cfg_t       cfg
);
  import gedd_pkg::*;

  logic [10:0] image_width_r;
  logic [7:0]  level_count_r;
  logic [7:0]  error_gain_r;
  logic        alpha_to_black_r;

  // divider state
  logic        busy_r;
  logic [2:0]  cnt_r;
  logic [7:0]  rem_r;
  logic [7:0]  quo_r;
  logic [7:0]  dv_r;

  logic        wr_req;
  reg_idx_t    idx;
  logic [7:0]  lc_eff_nxt;
  logic [8:0]  shifted;
  logic        fits;
  logic [7:0]  rem_nxt;

  assign pready = 1'b1;
  assign wr_req = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  // level count below 2 acts as 2
  assign lc_eff_nxt = (pwdata[7:0] < 8'd2) ? 8'd2 : pwdata[7:0];

  // restoring division step; the dividend 255 feeds in all ones
  assign shifted = {rem_r, 1'b1};
  assign fits    = shifted >= {1'b0, dv_r};
  assign rem_nxt = fits ? 8'(shifted - {1'b0, dv_r}) : shifted[7:0];

  // register writes and divider sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r    <= 11'd1024;
      level_count_r    <= 8'd2;
      error_gain_r     <= 8'd64;
      alpha_to_black_r <= 1'b0;
      busy_r           <= 1'b0;
      cnt_r            <= 3'd0;
      rem_r            <= 8'd0;
      quo_r            <= 8'd255;
      dv_r             <= 8'd1;
    end else begin
      if (wr_req) begin
        unique case (idx)
          REG_IMAGE_WIDTH:    image_width_r    <= pwdata[10:0];
          REG_LEVEL_COUNT: begin
            level_count_r <= pwdata[7:0];
            dv_r          <= lc_eff_nxt - 8'd1;
            busy_r        <= 1'b1;
            cnt_r         <= 3'd0;
            rem_r         <= 8'd0;
            quo_r         <= 8'd0;
          end
          REG_ERROR_GAIN:     error_gain_r     <= pwdata[7:0];
          REG_ALPHA_TO_BLACK: alpha_to_black_r <= pwdata[0];
        endcase
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[6:0], fits};
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // read-back
  always_comb begin
    unique case (idx)
      REG_IMAGE_WIDTH:    prdata = {21'd0, image_width_r};
      REG_LEVEL_COUNT:    prdata = {24'd0, level_count_r};
      REG_ERROR_GAIN:     prdata = {24'd0, error_gain_r};
      REG_ALPHA_TO_BLACK: prdata = {31'd0, alpha_to_black_r};
    endcase
  end

  assign cfg.image_width    = image_width_r;
  assign cfg.levels         = (level_count_r < 8'd2) ? 8'd2 : level_count_r;
  assign cfg.error_gain     = error_gain_r;
  assign cfg.alpha_to_black = alpha_to_black_r;
  assign cfg.level_step     = quo_r;
  assign cfg.step_busy      = busy_r;

endmodule

// ===== hw/rtl/gedd_front.sv =====
// ----------------------------------------------------------------------------
// gedd_front: pixel intake
// Accepts pixel requests, marks transparent pixels and queues them for
// the back end in a short register queue.
// ----------------------------------------------------------------------------
module gedd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic          in_start_of_frame,
  input  logic [7:0]    in_red,
  input  logic [7:0]    in_green,
  input  logic [7:0]    in_blue,
  input  logic [7:0]    in_alpha,
  output gedd_pkg::pix_t head,
  output logic          head_valid,
  input  logic          head_take
);
  import gedd_pkg::*;

  localparam int PW = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;

  pix_t            mem_r [FRONT_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW:0]     count_r;
  logic            wr_en;
  logic            rd_en;
  pix_t            pix_nxt;

  assign full       = count_r == (PW+1)'(FRONT_DEPTH);
  assign head_valid = count_r != '0;
  assign wr_en      = push & ~full;
  assign rd_en      = head_take & head_valid;
  assign head       = mem_r[rd_ptr_r];

  // classify the incoming pixel
  always_comb begin
    pix_nxt.sof         = in_start_of_frame;
    pix_nxt.red         = in_red;
    pix_nxt.green       = in_green;
    pix_nxt.blue        = in_blue;
    pix_nxt.alpha       = in_alpha;
    pix_nxt.transparent = in_alpha == 8'd0;
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= pix_nxt;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PW'(FRONT_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PW'(FRONT_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + (PW+1)'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - (PW+1)'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/gedd_back.sv =====
// ----------------------------------------------------------------------------
// gedd_back: error diffusion engine
// Sequences one pixel at a time through error add, luminance, quantize and
// error split, keeps the next-row error store and the result register.
// ----------------------------------------------------------------------------
module gedd_back #(
  parameter int MAX_WIDTH = gedd_pkg::MAX_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  gedd_pkg::cfg_t cfg,
  input  gedd_pkg::pix_t head,
  input  logic           head_valid,
  output logic           head_take,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_level_index,
  output logic [7:0]     out_red,
  output logic [7:0]     out_green,
  output logic [7:0]     out_blue,
  output logic [7:0]     out_alpha
);
  import gedd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;

  back_state_t state_r, state_nxt;

  // frame position and pending errors
  logic [CW-1:0]           col_r;
  logic                    first_r;
  logic signed [ERR_W-1:0] right_err_r;
  logic signed [ERR_W-1:0] bp0_r;
  logic signed [ERR_W-1:0] bp1_r;
  logic signed [ERR_W-1:0] hold_r;

  // datapath registers
  pix_t                pix_r;
  logic [7:0]          rc_r, gc_r, bc_r;
  logic [9:0]          sum3_r;
  logic [23:0]         pr_r, pg_r, pb_r;
  logic [23:0]         lsum_r;
  logic [16:0]         lumq_r;
  logic [7:0]          level_r;
  logic [7:0]          gray_r;
  logic signed [10:0]  d_r;
  logic signed [12:0]  q_r;
  logic                out_valid_r;

  // row store
  logic             ram_we;
  logic [CW-1:0]    ram_waddr;
  logic [ERR_W-1:0] ram_wdata;
  logic [CW-1:0]    ram_raddr;
  logic [ERR_W-1:0] ram_q;

  logic out_free;
  logic out_load;
  logic last;

  gedd_ram #(
    .WIDTH (ERR_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_q)
  );

  // clamp channel plus error to a byte
  function automatic logic [7:0] clamp8(input logic [7:0] ch,
                                        input logic signed [13:0] err);
    logic signed [14:0] s;
    s = $signed({7'd0, ch}) + {err[13], err};
    if (s < 0) begin
      return 8'd0;
    end else if (s > 15'sd255) begin
      return 8'd255;
    end
    return s[7:0];
  endfunction

  // divide by 16, truncating toward zero
  function automatic logic signed [12:0] div16(input logic signed [15:0] v);
    logic signed [15:0] a;
    logic signed [15:0] sh;
    a  = v + (v[15] ? 16'sd15 : 16'sd0);
    sh = a >>> 4;
    return sh[12:0];
  endfunction

  // effective row width and end-of-row detect
  logic [WW-1:0] iw_x, eff_w;
  assign iw_x  = WW'(cfg.image_width);
  assign eff_w = (iw_x == '0) ? WW'(1) :
                 (iw_x > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : iw_x;
  assign last  = (WW'(col_r) + WW'(1)) >= eff_w;

  // store address for the next pixel
  assign ram_raddr = head.sof ? '0 : col_r;

  // incoming error and clamp
  logic signed [13:0] e_in;
  assign e_in = {right_err_r[ERR_W-1], right_err_r} +
                (first_r ? 14'sd0 : {ram_q[ERR_W-1], $signed(ram_q)});

  // luminance terms
  logic [23:0] pr_nxt, pg_nxt, pb_nxt;
  assign pr_nxt = {16'd0, rc_r} * {10'd0, LUM_KR};
  assign pg_nxt = {16'd0, gc_r} * {8'd0, LUM_KG};
  assign pb_nxt = {16'd0, bc_r} * {11'd0, LUM_KB};

  // divide by 255 through reciprocal
  logic [48:0] recip_prod;
  assign recip_prod = {25'd0, lsum_r} * {24'd0, RECIP_255};

  // level = lum * N >> 16, capped
  logic [15:0] lum16;
  logic [23:0] lvl_prod;
  logic [7:0]  lvl_raw, level_nxt;
  assign lum16     = lumq_r[16] ? 16'hFFFF : lumq_r[15:0];
  assign lvl_prod  = {8'd0, lum16} * {16'd0, cfg.levels};
  assign lvl_raw   = lvl_prod[23:16];
  assign level_nxt = (lvl_raw > cfg.levels - 8'd1) ? cfg.levels - 8'd1 : lvl_raw;

  // gray value and raw error
  logic [15:0]        gray_prod;
  logic [7:0]         gray_nxt;
  logic [9:0]         gray3;
  logic signed [10:0] d_nxt;
  assign gray_prod = {8'd0, level_r} * {8'd0, cfg.level_step};
  assign gray_nxt  = gray_prod[7:0];
  assign gray3     = {2'd0, gray_nxt} + {1'b0, gray_nxt, 1'b0};
  assign d_nxt     = $signed({1'b0, sum3_r}) - $signed({1'b0, gray3});

  // gain, Q2.6, truncated toward zero
  logic signed [19:0] gp, gp_adj, gp_sh;
  logic signed [12:0] q_nxt;
  assign gp     = {{9{d_r[10]}}, d_r} * $signed({12'd0, cfg.error_gain});
  assign gp_adj = gp + (gp[19] ? 20'sd63 : 20'sd0);
  assign gp_sh  = gp_adj >>> 6;
  assign q_nxt  = pix_r.transparent ? 13'sd0 : gp_sh[12:0];

  // error shares
  logic signed [15:0]      qx, q7, q5, q3;
  logic signed [ERR_W-1:0] s7, s5, s3, s1, bp0_sum, nb0;
  assign qx      = {{3{q_r[12]}}, q_r};
  assign q7      = (qx <<< 3) - qx;
  assign q5      = (qx <<< 2) + qx;
  assign q3      = (qx <<< 1) + qx;
  assign s7      = div16(q7);
  assign s5      = div16(q5);
  assign s3      = div16(q3);
  assign s1      = div16(qx);
  assign bp0_sum = bp0_r + s3;
  assign nb0     = bp1_r + s5;

  assign out_free = ~out_valid_r | pop;
  assign empty    = ~out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (head_valid && !cfg.step_busy) state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_PROD;
      ST_PROD: state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_LVL;
      ST_LVL:  state_nxt = ST_GRAY;
      ST_GRAY: state_nxt = ST_Q;
      ST_Q:    state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) state_nxt = last ? ST_LAST : ST_IDLE;
      end
      ST_LAST: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    head_take = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = col_r;
    ram_wdata = hold_r;
    unique case (state_r)
      ST_IDLE: head_take = head_valid & ~cfg.step_busy;
      ST_FIN: begin
        out_load  = out_free;
        ram_we    = out_free & (col_r != '0);
        ram_waddr = col_r - CW'(1);
        ram_wdata = bp0_sum;
      end
      ST_LAST: ram_we = 1'b1;
      default: ;
    endcase
  end

  // control state and pending errors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      first_r     <= 1'b1;
      right_err_r <= '0;
      bp0_r       <= '0;
      bp1_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // start of frame restarts the row and drops the pending errors
      if (head_take && head.sof) begin
        col_r       <= '0;
        first_r     <= 1'b1;
        right_err_r <= '0;
        bp0_r       <= '0;
        bp1_r       <= '0;
      end
      if (out_load) begin
        right_err_r <= last ? '0 : s7;
        if (!last) begin
          bp0_r <= nb0;
          bp1_r <= s1;
          col_r <= col_r + CW'(1);
        end
      end
      if (state_r == ST_LAST) begin
        bp0_r   <= '0;
        bp1_r   <= '0;
        col_r   <= '0;
        first_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (head_take) pix_r <= head;
    if (state_r == ST_ADD) begin
      rc_r <= clamp8(pix_r.red, e_in);
      gc_r <= clamp8(pix_r.green, e_in);
      bc_r <= clamp8(pix_r.blue, e_in);
    end
    if (state_r == ST_PROD) begin
      pr_r   <= pr_nxt;
      pg_r   <= pg_nxt;
      pb_r   <= pb_nxt;
      sum3_r <= {2'd0, rc_r} + {2'd0, gc_r} + {2'd0, bc_r};
    end
    if (state_r == ST_SUM)  lsum_r  <= pr_r + pg_r + pb_r;
    if (state_r == ST_DIV)  lumq_r  <= recip_prod[48:32];
    if (state_r == ST_LVL)  level_r <= level_nxt;
    if (state_r == ST_GRAY) begin
      gray_r <= gray_nxt;
      d_r    <= d_nxt;
    end
    if (state_r == ST_Q) q_r <= q_nxt;
    if (out_load && last) hold_r <= nb0;
    // result register
    if (out_load) begin
      if (pix_r.transparent) begin
        if (cfg.alpha_to_black) begin
          out_level_index <= 8'd1;
          out_red         <= 8'd0;
          out_green       <= 8'd0;
          out_blue        <= 8'd0;
          out_alpha       <= 8'd255;
        end else begin
          out_level_index <= 8'd0;
          out_red         <= rc_r;
          out_green       <= gc_r;
          out_blue        <= bc_r;
          out_alpha       <= pix_r.alpha;
        end
      end else begin
        out_level_index <= level_r + 8'd1;
        out_red         <= gray_r;
        out_green       <= gray_r;
        out_blue        <= gray_r;
        out_alpha       <= pix_r.alpha;
      end
    end
  end

endmodule

// ===== hw/rtl/gray_error_diffusion_dither_top.sv =====
// ----------------------------------------------------------------------------
// gray_error_diffusion_dither_top: grayscale Floyd-Steinberg ditherer
// Quantizes a raster stream of RGBA pixels to N gray levels with error
// diffusion to the right and next-row neighbors.
//
// Usage:
//   Pixels enter through push/full, start_of_frame marks the first pixel of
//   each image. Results leave through empty/pop, one per pixel, in order.
//   Setup registers (image_width, level_count, error_gain, alpha_to_black)
//   sit on the APB port at byte addresses 0, 4, 8, 12; write them only
//   while no pixel is in flight.
//   Each pixel steps through the engine states add, product, sum, divide,
//   level, gray, quantize and finish (plus last at the end of a row) before
//   the next is taken: the error handed right to the next pixel comes out of
//   the full add/luminance/quantize/gain chain. A level_count write starts
//   the bit-serial step divider; pixels wait in the queue until it finishes.
//   A 4-entry queue keeps taking pixels while a result waits; if pop stays
//   low the engine holds its finished pixel and push backs up once the queue
//   is full. Reset empties both sides, restores register defaults and
//   starts a fresh frame; the row error store is not cleared.
// ----------------------------------------------------------------------------
module gray_error_diffusion_dither_top #(
  parameter int MAX_WIDTH = gedd_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // pixel input
  input  logic        push,
  output logic        full,
  input  logic        in_start_of_frame,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  // results
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_level_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  // setup port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gedd_pkg::*;

  cfg_t cfg;
  pix_t head;
  logic head_valid;
  logic head_take;

  // setup registers
  gedd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // intake queue
  gedd_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_start_of_frame (in_start_of_frame),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_alpha          (in_alpha),
    .head              (head),
    .head_valid        (head_valid),
    .head_take         (head_take)
  );

  // diffusion engine
  gedd_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .head            (head),
    .head_valid      (head_valid),
    .head_take       (head_take),
    .empty           (empty),
    .pop             (pop),
    .out_level_index (out_level_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha)
  );

endmodule
